### rtl/ict_pkg.sv
// Shared types and constants of the INI settings tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package ict_pkg;

  localparam int unsigned MAX_TOKEN_LENGTH_DEF = 1023;

  // Results one input beat can cause: identifier end, text, token end,
  // flushed token end, end token.
  localparam int unsigned MAX_RES   = 5;
  localparam int unsigned RES_IDX_W = $clog2(MAX_RES);
  localparam int unsigned RES_CNT_W = $clog2(MAX_RES + 1);

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef logic [2:0] kind_t;

  localparam kind_t K_EQUALS  = 3'd0;
  localparam kind_t K_COMMA   = 3'd1;
  localparam kind_t K_IDENT   = 3'd2;
  localparam kind_t K_STRING  = 3'd3;
  localparam kind_t K_COMMENT = 3'd4;
  localparam kind_t K_HEADER  = 3'd5;
  localparam kind_t K_END     = 3'd6;

  typedef struct packed {
    logic       event_kind;
    logic [7:0] text_byte;
    kind_t      token_kind;
    logic [9:0] token_length;
    logic       last_result;
  } result_t;

  // All results of one input beat, in order.
  typedef struct packed {
    logic [RES_CNT_W-1:0]  count;
    result_t [MAX_RES-1:0] res;
  } bundle_t;

endpackage
`default_nettype wire

### rtl/ict_if.sv
// Channel interfaces: raw byte input and token event output.
`timescale 1ns / 1ps
`default_nettype none
interface ict_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_stream;

  modport source(output valid, output byte_in, output end_of_stream, input ready);
  modport sink(input valid, input byte_in, input end_of_stream, output ready);
endinterface

interface ict_out_if;
  logic       valid;
  logic       ready;
  logic       event_kind;
  logic [7:0] text_byte;
  logic [2:0] token_kind;
  logic [9:0] token_length;
  logic       last_result;

  modport source(output valid, output event_kind, output text_byte, output token_kind,
                 output token_length, output last_result, input ready);
  modport sink(input valid, input event_kind, input text_byte, input token_kind,
               input token_length, input last_result, output ready);
endinterface
`default_nettype wire

### rtl/ini_config_tokenizer_unit.sv
// Top level of the INI settings tokenizer.
// stream carries raw file bytes, one per beat; a beat with end_of_stream set
// closes the file and its byte is ignored. tokens carries events: text beats
// (event_kind 0) with each kept byte of the current token, and token-end beats
// (event_kind 1) with kind and saturated length. last_result marks the final
// event caused by an input beat; a beat may cause none.
// Each byte is held until the next beat arrives, so its events come out after
// the following beat. Those events pass through a queue entry and then the
// output stage register before they appear on tokens. Input takes one beat per
// cycle while the queue has room; the output side sends one event per cycle
// while tokens.ready is high, so the events of a beat leave one after another.
// A two-entry bundle queue lets the input keep accepting while the output works
// off earlier events or is stalled; when it is full, stream.ready drops until
// the output drains. Reset clears the lexer to between-token state with nothing
// held and empties the queue and output stage; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module ini_config_tokenizer_unit #(
  parameter int unsigned MAX_TOKEN_LENGTH = ict_pkg::MAX_TOKEN_LENGTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ict_in_if.sink    stream,
  ict_out_if.source tokens
);
  import ict_pkg::*;

  bundle_t push_data;
  logic    push_valid;
  logic    push_ready;
  bundle_t pop_data;
  logic    pop_valid;
  logic    pop_ready;

  ict_front #(
    .MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (stream),
    .push_data (push_data),
    .push_valid(push_valid),
    .push_ready(push_ready)
  );

  ict_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_data (push_data),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .pop_data  (pop_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready)
  );

  ict_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_data (pop_data),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .out_ch   (tokens)
  );

endmodule
`default_nettype wire

### rtl/ict_front.sv
// Front end: lookahead hold, lexer state and per-beat result bundle.
`timescale 1ns / 1ps
`default_nettype none
module ict_front #(
  parameter int unsigned MAX_TOKEN_LENGTH = ict_pkg::MAX_TOKEN_LENGTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  ict_in_if.sink           in_ch,
  output ict_pkg::bundle_t push_data,
  output logic             push_valid,
  input  logic             push_ready
);
  import ict_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_TOKEN_LENGTH + 1);

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_EQUALS = 8'h3d;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_DEL    = 8'h7f;

  typedef enum logic [2:0] {
    M_IDLE   = 3'd0,
    M_IDENT  = 3'd1,
    M_STRING = 3'd2,
    M_LINE   = 3'd3,
    M_BLOCK  = 3'd4,
    M_HEADER = 3'd5
  } mode_t;

  // What lexing one held byte does: an end before its text, its text,
  // an end after it, and the mode it leaves.
  typedef struct packed {
    logic  pre_end;
    kind_t pre_kind;
    logic  text;
    logic  post_end;
    kind_t post_kind;
    mode_t mode_next;
    logic  closing_next;
  } step_t;

  mode_t            mode;
  logic [7:0]       held_byte;
  logic             held_valid;
  logic [CNT_W-1:0] kept;
  logic             closing;

  step_t            st;
  logic [CNT_W-1:0] cnt_v;
  mode_t            mode_v;
  logic             closing_v;
  logic [RES_CNT_W-1:0] n;
  result_t [MAX_RES-1:0] res;
  kind_t            flush_kind;
  logic             accept;

  function automatic step_t lex_idle(input step_t base, input logic [7:0] c,
                                     input logic [7:0] la, input logic la_ok);
    step_t s;
    s = base;
    case (c)
      CH_EQUALS: begin
        s.text = 1'b1; s.post_end = 1'b1; s.post_kind = K_EQUALS;
      end
      CH_COMMA: begin
        s.text = 1'b1; s.post_end = 1'b1; s.post_kind = K_COMMA;
      end
      CH_LBRACK: begin s.text = 1'b1; s.mode_next = M_HEADER; end
      CH_QUOTE:  begin s.text = 1'b1; s.mode_next = M_STRING; end
      CH_SEMI:   begin s.text = 1'b1; s.mode_next = M_LINE;   end
      CH_SLASH: begin
        s.text = 1'b1;
        if (la_ok && la == CH_STAR)       s.mode_next = M_BLOCK;
        else if (la_ok && la == CH_SLASH) s.mode_next = M_LINE;
        else                              s.mode_next = M_IDENT;
      end
      default: begin
        if (c > CH_SPACE && c != CH_DEL) begin
          s.text = 1'b1; s.mode_next = M_IDENT;
        end
      end
    endcase
    return s;
  endfunction

  function automatic step_t lex_byte(input mode_t m, input logic cl, input logic [7:0] c,
                                     input logic [7:0] la, input logic la_ok);
    step_t s;
    s = '0;
    s.mode_next = m;
    if (cl) begin
      // '*' seen before '/': this byte closes the block comment
      s.text = 1'b1; s.post_end = 1'b1; s.post_kind = K_COMMENT;
    end else begin
      case (m)
        M_IDENT: begin
          if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
            s.pre_end = 1'b1; s.pre_kind = K_IDENT; s.mode_next = M_IDLE;
          end else if (c == CH_EQUALS || c == CH_COMMA || c == CH_QUOTE ||
                       c == CH_SLASH) begin
            s.pre_end = 1'b1; s.pre_kind = K_IDENT; s.mode_next = M_IDLE;
            s = lex_idle(s, c, la, la_ok);
          end else begin
            s.text = 1'b1;
          end
        end
        M_STRING: begin
          if (c == CH_QUOTE) begin
            s.text = 1'b1; s.post_end = 1'b1; s.post_kind = K_STRING;
          end else if (c != CH_BSLASH) begin
            s.text = 1'b1;
          end
        end
        M_LINE: begin
          s.text = 1'b1;
          if (c == CH_LF || c == CH_CR) begin
            s.post_end = 1'b1; s.post_kind = K_COMMENT;
          end
        end
        M_BLOCK: begin
          s.text = 1'b1;
          if (c == CH_STAR && la_ok && la == CH_SLASH) s.closing_next = 1'b1;
        end
        M_HEADER: begin
          s.text = 1'b1;
          if (c == CH_RBRACK) begin
            s.post_end = 1'b1; s.post_kind = K_HEADER;
          end
        end
        default: s = lex_idle(s, c, la, la_ok);
      endcase
    end
    return s;
  endfunction

  function automatic result_t end_res(input kind_t k, input logic [CNT_W-1:0] cnt);
    result_t          r;
    logic [CNT_W+9:0] wide;
    r = '0;
    wide = {10'd0, cnt};
    r.event_kind   = 1'b1;
    r.token_kind   = k;
    r.token_length = wide[9:0];
    return r;
  endfunction

  function automatic result_t text_res(input logic [7:0] c);
    result_t r;
    r = '0;
    r.text_byte = c;
    return r;
  endfunction

  always_comb begin
    st = lex_byte(mode, closing, held_byte, in_ch.byte_in, !in_ch.end_of_stream);
    if (!held_valid) begin
      st.pre_end      = 1'b0;
      st.text         = 1'b0;
      st.post_end     = 1'b0;
      st.mode_next    = mode;
      st.closing_next = closing;
    end
    cnt_v      = kept;
    mode_v     = st.mode_next;
    closing_v  = st.closing_next;
    n          = '0;
    res        = '0;
    flush_kind = K_IDENT;

    if (st.pre_end) begin
      res[n] = end_res(st.pre_kind, cnt_v);
      cnt_v  = '0;
      n      = n + RES_CNT_W'(1);
    end
    if (st.text) begin
      if (cnt_v < CNT_W'(MAX_TOKEN_LENGTH)) cnt_v = cnt_v + CNT_W'(1);
      res[n] = text_res(held_byte);
      n      = n + RES_CNT_W'(1);
    end
    if (st.post_end) begin
      res[n] = end_res(st.post_kind, cnt_v);
      cnt_v  = '0;
      n      = n + RES_CNT_W'(1);
      mode_v = M_IDLE;
    end

    if (in_ch.end_of_stream) begin
      closing_v = 1'b0;
      if (mode_v == M_STRING)                         flush_kind = K_STRING;
      else if (mode_v == M_LINE || mode_v == M_BLOCK) flush_kind = K_COMMENT;
      else                                            flush_kind = K_IDENT;
      // a pending single-byte token gets no end result
      if (cnt_v > CNT_W'(1)) begin
        res[n] = end_res(flush_kind, cnt_v);
        cnt_v  = '0;
        n      = n + RES_CNT_W'(1);
      end
      res[n] = end_res(K_END, cnt_v);
      n      = n + RES_CNT_W'(1);
    end

    if (n != '0) res[n - RES_CNT_W'(1)].last_result = 1'b1;
  end

  assign in_ch.ready     = push_ready;
  assign accept          = in_ch.valid && push_ready;
  assign push_valid      = in_ch.valid && (n != '0);
  assign push_data.count = n;
  assign push_data.res   = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      held_byte  <= '0;
      held_valid <= 1'b0;
      kept       <= '0;
      closing    <= 1'b0;
    end else if (accept) begin
      if (in_ch.end_of_stream) begin
        mode       <= M_IDLE;
        held_byte  <= '0;
        held_valid <= 1'b0;
        kept       <= '0;
        closing    <= 1'b0;
      end else begin
        mode       <= mode_v;
        held_byte  <= in_ch.byte_in;
        held_valid <= 1'b1;
        kept       <= cnt_v;
        closing    <= closing_v;
      end
    end
  end

  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.end_of_stream |=> !held_valid && mode == M_IDLE && kept == '0 && !closing)
    else $error("end of stream did not return lexer to idle");

  a_eos_ends: assert property (@(posedge clk) disable iff (rst)
    push_valid && push_ready && in_ch.end_of_stream |->
      push_data.res[push_data.count - RES_CNT_W'(1)].event_kind &&
      push_data.res[push_data.count - RES_CNT_W'(1)].token_kind == K_END)
    else $error("end of stream bundle does not close with end token");

  a_first_silent: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && !held_valid && !in_ch.end_of_stream |-> !push_valid)
    else $error("results produced without a held byte");

endmodule
`default_nettype wire

### rtl/ict_queue.sv
// Short bundle queue between the lexer front end and the output sequencer.
`timescale 1ns / 1ps
`default_nettype none
module ict_queue (
  input  logic             clk,
  input  logic             rst,
  input  ict_pkg::bundle_t push_data,
  input  logic             push_valid,
  output logic             push_ready,
  output ict_pkg::bundle_t pop_data,
  output logic             pop_valid,
  input  logic             pop_ready
);
  import ict_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  bundle_t          mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop)      fill <= fill + CNT_W'(1);
      else if (do_pop && !do_push) fill <= fill - CNT_W'(1);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill out of range");

endmodule
`default_nettype wire

### rtl/ict_back.sv
// Back end: walks a result bundle out one beat per cycle while out_ch.ready is high.
`timescale 1ns / 1ps
`default_nettype none
module ict_back (
  input  logic             clk,
  input  logic             rst,
  input  ict_pkg::bundle_t pop_data,
  input  logic             pop_valid,
  output logic             pop_ready,
  ict_out_if.source        out_ch
);
  import ict_pkg::*;

  bundle_t              cur;
  logic                 cur_valid;
  logic [RES_IDX_W-1:0] idx;
  result_t              sel;

  assign sel       = cur.res[idx];
  assign pop_ready = !cur_valid || (out_ch.ready && sel.last_result);

  assign out_ch.valid        = cur_valid;
  assign out_ch.event_kind   = sel.event_kind;
  assign out_ch.text_byte    = sel.text_byte;
  assign out_ch.token_kind   = sel.token_kind;
  assign out_ch.token_length = sel.token_length;
  assign out_ch.last_result  = sel.last_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop_ready) begin
      cur_valid <= pop_valid;
      idx       <= '0;
      if (pop_valid) cur <= pop_data;
    end else if (out_ch.ready) begin
      idx <= idx + RES_IDX_W'(1);
    end
  end

  a_idx_in_bundle: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> RES_CNT_W'(idx) < cur.count)
    else $error("result index past end of bundle");

endmodule
`default_nettype wire
